/* sv/dtr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dtr_pkg;

    // Request codes carried in the mode field.
    localparam logic [1:0] MODE_UPSERT = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_DUE    = 2'd2;
    localparam logic [1:0] MODE_RETRY  = 2'd3;

    localparam logic [7:0] RETRY_LIMIT_RESET = 8'd5;

    // Backoff values in seconds: 5 s doubled per retry, capped at 300 s.
    localparam logic [8:0] BACKOFF_BASE = 9'd5;
    localparam logic [8:0] BACKOFF_CAP  = 9'd300;

    typedef struct packed {
        logic [1:0]  mode;
        logic [6:0]  device;
        logic [7:0]  action;
        logic [31:0] deadline;
        logic [7:0]  retries;
        logic [31:0] now;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic [6:0]  out_device;
        logic [7:0]  out_action;
        logic [31:0] out_deadline;
        logic [7:0]  out_retries;
        logic [4:0]  active_count;
    } out_item_t;

    // One stored row; the valid bit lives in flip-flops outside the memory.
    typedef struct packed {
        logic [6:0]  device;
        logic [7:0]  action;
        logic [31:0] deadline;
        logic [7:0]  retries;
    } row_t;

    // Outcome flags of one pass over the table.
    typedef struct packed {
        logic sel_found;
        logic free_found;
    } scan_flags_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Backoff for a retry count already incremented.
    function automatic logic [8:0] backoff_of(input logic [7:0] r);
        logic [8:0] d;
        begin
            unique case (r)
                8'd0:    d = BACKOFF_BASE;
                8'd1:    d = BACKOFF_BASE << 1;
                8'd2:    d = BACKOFF_BASE << 2;
                8'd3:    d = BACKOFF_BASE << 3;
                8'd4:    d = BACKOFF_BASE << 4;
                8'd5:    d = BACKOFF_BASE << 5;
                default: d = BACKOFF_CAP;
            endcase
            return d;
        end
    endfunction

endpackage

`default_nettype wire

/* sv/dtr_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module dtr_ram #(
    parameter int WIDTH = 55,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/dtr_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

module dtr_scan
    import dtr_pkg::*;
#(
    parameter int ENTRIES = 16,
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic             chk_valid,
    input  wire logic [IDX_W-1:0] chk_idx,
    input  wire logic             row_valid,
    input  wire row_t             rd_row,
    input  wire logic [1:0]       req_mode,
    input  wire logic [6:0]       req_device,
    input  wire logic [31:0]      req_now,
    output scan_flags_t           flags,
    output logic      [IDX_W-1:0] sel_idx,
    output row_t                  sel_row,
    output logic      [IDX_W-1:0] free_idx
);

    scan_flags_t flags_reg, flags_next;
    logic [IDX_W-1:0] sel_idx_reg, free_idx_reg;
    row_t sel_row_reg;
    logic take_sel, take_free, lookup_hit, due_hit;

    // For a due query the selected row is the earliest expired one, scanning
    // upward so that the lowest row wins a tie; otherwise it is the device's row.
    always_comb begin
        lookup_hit = row_valid && (rd_row.device == req_device) && !flags_reg.sel_found;
        due_hit    = row_valid && (rd_row.deadline <= req_now)
                     && (!flags_reg.sel_found || (rd_row.deadline < sel_row_reg.deadline));
        take_sel   = chk_valid && ((req_mode == MODE_DUE) ? due_hit : lookup_hit);
        take_free  = chk_valid && !row_valid && !flags_reg.free_found;
        flags_next = flags_reg;
        if (start) begin
            flags_next = '0;
        end else begin
            if (take_sel) begin
                flags_next.sel_found = 1'b1;
            end
            if (take_free) begin
                flags_next.free_found = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!start && take_sel) begin
            sel_idx_reg <= chk_idx;
            sel_row_reg <= rd_row;
        end
        if (!start && take_free) begin
            free_idx_reg <= chk_idx;
        end
    end

    assign flags    = flags_reg;
    assign sel_idx  = sel_idx_reg;
    assign sel_row  = sel_row_reg;
    assign free_idx = free_idx_reg;

endmodule

`default_nettype wire

/* sv/deadline_retry_table.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// s_        in         s_valid / s_ready     s_data (in_item_t)
// m_        out        m_valid / m_ready     m_data (out_item_t)
// cfg_      in         cfg_valid / cfg_ready cfg_wdata (retry limit, 8 bits)
//
// Each request reads every row in turn; each row is checked as it returns
// from memory, and once the last row is checked the chosen row is written
// back as the result is registered. The block accepts a new request only
// after the last one is through and it is back in idle.
// Reset is synchronous and active low; it frees every row and sets the retry
// limit to 5. A stalled result holds the write-back until the output frees.

module deadline_retry_table
    import dtr_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [7:0] cfg_wdata
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int ROW_W = $bits(row_t);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t state_reg, state_next;
    in_item_t req_reg, req_next;
    logic [7:0] retry_limit_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic issue_done_reg, issue_done_next;
    logic chk_valid_reg;
    logic [IDX_W-1:0] chk_idx_reg;
    logic m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    logic accept, issue, start, fin_go;
    logic ram_we;
    logic [IDX_W-1:0] ram_waddr;
    row_t ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    row_t rd_row;
    scan_flags_t flags;
    logic [IDX_W-1:0] sel_idx, free_idx;
    row_t sel_row;
    logic [7:0] new_retries;
    logic [31:0] new_deadline;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign start     = accept;
    assign issue     = (state_reg == ST_SCAN) && !issue_done_reg;
    assign rd_row    = row_t'(ram_rdata);

    // Retry update: bump the count, then push the deadline out from now.
    assign new_retries  = sel_row.retries + 8'd1;
    assign new_deadline = req_reg.now + 32'(backoff_of(new_retries));

    dtr_ram #(
        .WIDTH(ROW_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (scan_cnt_reg),
        .rdata (ram_rdata)
    );

    dtr_scan #(
        .ENTRIES(ENTRIES)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .chk_valid  (chk_valid_reg),
        .chk_idx    (chk_idx_reg),
        .row_valid  (valid_reg[chk_idx_reg]),
        .rd_row     (rd_row),
        .req_mode   (req_reg.mode),
        .req_device (req_reg.device),
        .req_now    (req_reg.now),
        .flags      (flags),
        .sel_idx    (sel_idx),
        .sel_row    (sel_row),
        .free_idx   (free_idx)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            retry_limit_reg <= RETRY_LIMIT_RESET;
            valid_reg       <= '0;
            cnt_reg         <= '0;
            issue_done_reg  <= 1'b0;
            chk_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            cnt_reg        <= cnt_next;
            issue_done_reg <= issue_done_next;
            chk_valid_reg  <= issue;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                retry_limit_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        scan_cnt_reg <= scan_cnt_next;
        chk_idx_reg  <= scan_cnt_reg;
        m_data_reg   <= m_data_next;
    end

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        scan_cnt_next   = scan_cnt_reg;
        issue_done_next = issue_done_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        s_ready         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = sel_idx;
        ram_wdata       = sel_row;
        fin_go          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next        = s_data;
                    scan_cnt_next   = '0;
                    issue_done_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    if (scan_cnt_reg == LAST_IDX) begin
                        issue_done_next = 1'b1;
                    end else begin
                        scan_cnt_next = scan_cnt_reg + 1'b1;
                    end
                end
                if (chk_valid_reg && (chk_idx_reg == LAST_IDX)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Wait here while an earlier result still sits in the output register.
                fin_go = !m_valid_reg || m_ready;
                if (fin_go) begin
                    m_data_next = '0;
                    unique case (req_reg.mode)
                        MODE_UPSERT: begin
                            if (flags.sel_found || flags.free_found) begin
                                ram_we    = 1'b1;
                                ram_waddr = flags.sel_found ? sel_idx : free_idx;
                                ram_wdata = '{device:   req_reg.device,
                                              action:   req_reg.action,
                                              deadline: req_reg.deadline,
                                              retries:  req_reg.retries};
                                valid_next[ram_waddr] = 1'b1;
                                if (!flags.sel_found) begin
                                    cnt_next = cnt_reg + 1'b1;
                                end
                                m_data_next.hit          = 1'b1;
                                m_data_next.out_device   = req_reg.device;
                                m_data_next.out_action   = req_reg.action;
                                m_data_next.out_deadline = req_reg.deadline;
                                m_data_next.out_retries  = req_reg.retries;
                            end
                        end
                        MODE_CLEAR: begin
                            // Only the valid bit is dropped; an upsert rewrites all fields.
                            if (flags.sel_found) begin
                                valid_next[sel_idx]      = 1'b0;
                                cnt_next                 = cnt_reg - 1'b1;
                                m_data_next.hit          = 1'b1;
                                m_data_next.out_device   = sel_row.device;
                                m_data_next.out_action   = sel_row.action;
                                m_data_next.out_deadline = sel_row.deadline;
                                m_data_next.out_retries  = sel_row.retries;
                            end
                        end
                        MODE_DUE: begin
                            if (flags.sel_found) begin
                                m_data_next.hit          = 1'b1;
                                m_data_next.out_device   = sel_row.device;
                                m_data_next.out_action   = sel_row.action;
                                m_data_next.out_deadline = sel_row.deadline;
                                m_data_next.out_retries  = sel_row.retries;
                            end
                        end
                        MODE_RETRY: begin
                            if (flags.sel_found && (sel_row.retries < retry_limit_reg)) begin
                                ram_we    = 1'b1;
                                ram_waddr = sel_idx;
                                ram_wdata = '{device:   sel_row.device,
                                              action:   sel_row.action,
                                              deadline: new_deadline,
                                              retries:  new_retries};
                                m_data_next.hit          = 1'b1;
                                m_data_next.out_device   = sel_row.device;
                                m_data_next.out_action   = sel_row.action;
                                m_data_next.out_deadline = new_deadline;
                                m_data_next.out_retries  = new_retries;
                            end
                        end
                        default: begin
                        end
                    endcase
                    m_data_next.active_count = 5'(cnt_next);
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The active count always matches the number of valid rows.
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == CNT_W'($countones(valid_reg)))
        else $error("active count differs from number of valid rows");

    // An accepted request always starts a table pass.
    a_accept_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_SCAN) && !issue_done_reg && !chk_valid_reg)
        else $error("accepted request did not start a scan");

    // An upsert finds no row only when the table is full.
    a_upsert_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) && (req_reg.mode == MODE_UPSERT)
        && !flags.sel_found && !flags.free_found |-> cnt_reg == CNT_W'(ENTRIES))
        else $error("upsert dropped while a row was free");

    // The row memory is written only in the write-back cycle.
    a_write_in_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_FINISH) && fin_go)
        else $error("row memory written outside write-back");

    // A result appears in the cycle after a write-back.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_go |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("write-back produced no result");

endmodule

`default_nettype wire
